FILE: hw/rtl/grc_pkg.sv
// Shared widths, codes and types of the glyph lookup engine.
package grc_pkg;

    localparam int FONT_SETS_D    = 2;
    localparam int CODE_SETS_D    = 64;
    localparam int WAYS_D         = 8;
    localparam int RADIX_BITS_D   = 4;
    localparam int RADIX_LEVELS_D = 4;
    localparam int INDEX_WORDS_D  = 4096;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 12;
    localparam int WORD_W     = 16;
    localparam int CODE_W     = 21;
    localparam int REC_W      = 64;
    localparam int STAT_W     = 3;
    localparam int FONT_W     = 8;
    localparam int BASE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FONT_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_HIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOFONT = 3'd4;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_FILL   = 3'd2,
        OP_NOFONT = 3'd3,
        OP_NOP    = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  table_address;
        logic [WORD_W-1:0]  table_word;
        logic [CODE_W-1:0]  code_point;
        logic [REC_W-1:0]   glyph_record;
    } t_cmd;

endpackage

FILE: hw/rtl/grc_in_if.sv
// Input item channel of the glyph lookup engine.
interface grc_in_if;
    import grc_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   table_address;
    logic [WORD_W-1:0]   table_word;
    logic [CODE_W-1:0]   code_point;
    logic [REC_W-1:0]    glyph_record;

    modport source (output valid, kind, table_address, table_word, code_point, glyph_record,
                    input ready);
    modport sink   (input valid, kind, table_address, table_word, code_point, glyph_record,
                    output ready);
endinterface

FILE: hw/rtl/grc_out_if.sv
// Result channel of the glyph lookup engine.
interface grc_out_if;
    import grc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [REC_W-1:0]    hit_record;
    logic [WORD_W-1:0]   record_number;

    modport source (output valid, status, hit_record, record_number, input ready);
    modport sink   (input valid, status, hit_record, record_number, output ready);
endinterface

FILE: hw/rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/grc_front.sv
// Front end: accept items, classify them and queue them for the back end.
module grc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_font_sel,
    input  logic           i_clearing,
    grc_in_if.sink         i_item,
    output logic           o_cmd_valid,
    output grc_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    import grc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    t_cmd       cmd;
    logic       accept;

    assign i_item.ready = (r_count != 2'd2) && !i_clearing;
    assign accept       = i_item.valid && i_item.ready;

    // classify; font state must stay stable while items are in flight, which the block does not enforce
    always_comb begin
        cmd.table_address = i_item.table_address;
        cmd.table_word    = i_item.table_word;
        cmd.code_point    = i_item.code_point;
        cmd.glyph_record  = i_item.glyph_record;
        case (i_item.kind)
            KIND_LOAD:   cmd.op = OP_LOAD;
            KIND_LOOKUP: cmd.op = i_font_sel ? OP_LOOKUP : OP_NOFONT;
            KIND_FILL:   cmd.op = i_font_sel ? OP_FILL : OP_NOFONT;
            default:     cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_wr <= !r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(accept) - 2'(i_cmd_pop);
        end
    end

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];
endmodule

FILE: hw/rtl/grc_back.sv
// Back end: clearing pass, index load, cache search, radix walk, cache fill and result register.
module grc_back #(
    parameter int FONT_SETS    = grc_pkg::FONT_SETS_D,
    parameter int CODE_SETS    = grc_pkg::CODE_SETS_D,
    parameter int WAYS         = grc_pkg::WAYS_D,
    parameter int RADIX_BITS   = grc_pkg::RADIX_BITS_D,
    parameter int RADIX_LEVELS = grc_pkg::RADIX_LEVELS_D,
    parameter int INDEX_WORDS  = grc_pkg::INDEX_WORDS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [grc_pkg::FONT_W-1:0]  i_font_id,
    input  logic [grc_pkg::BASE_W-1:0]  i_index_base,
    input  logic                        i_cmd_valid,
    input  grc_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_clearing,
    grc_out_if.source                   o_result
);
    import grc_pkg::*;

    localparam int SETS   = FONT_SETS * CODE_SETS;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int PTR_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W  = $clog2(INDEX_WORDS);
    localparam int LVL_W  = (RADIX_LEVELS > 1) ? $clog2(RADIX_LEVELS) : 1;
    localparam int LINE_W = 1 + CODE_W + FONT_W + REC_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_TAG   = 5'b00100,
        S_WALK  = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [SET_W-1:0]   r_clr, n_clr;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [REC_W-1:0]   r_out_hit, n_out_hit;
    logic [WORD_W-1:0]  r_out_num, n_out_num;

    logic               pop, idx_we, fill_we;
    logic [CODE_W-1:0]  set_code;
    logic [31:0]        set_full;
    logic [SET_W-1:0]   set_idx;
    logic [LVL_W-1:0]   walk_lvl;
    logic [WORD_W-1:0]  walk_node;
    logic [63:0]        key_full;
    logic [31:0]        addr_full;
    logic [31:0]        load_full;
    logic [WORD_W-1:0]  idx_rdata;
    logic [LINE_W-1:0]  line [WAYS];
    logic [WAYS-1:0]    way_hit;
    logic               hit_any;
    logic [REC_W-1:0]   hit_rec;
    logic [PTR_W-1:0]   ptr_rdata, fill_way, fill_next;
    logic [LINE_W-1:0]  way_wdata;
    logic [SET_W-1:0]   way_waddr;

    // set = font part * CODE_SETS + code part
    assign set_code = (r_state == S_IDLE) ? i_cmd.code_point : r_cmd.code_point;
    assign set_full = ((32'(i_font_id) & 32'(FONT_SETS - 1)) * 32'(CODE_SETS))
                    + (32'(set_code) & 32'(CODE_SETS - 1));
    assign set_idx  = set_full[SET_W-1:0];

    // radix walk address
    assign walk_lvl  = (r_state == S_TAG) ? LVL_W'(RADIX_LEVELS - 1) : r_lvl - LVL_W'(1);
    assign walk_node = (r_state == S_TAG) ? '0 : idx_rdata;
    assign key_full  = (64'(r_cmd.code_point) >> (32'(walk_lvl) * RADIX_BITS))
                     & ((64'd1 << RADIX_BITS) - 64'd1);
    assign addr_full = 32'(i_index_base) + (32'(walk_node) << RADIX_BITS)
                     + 32'(key_full[RADIX_BITS-1:0]);
    assign load_full = 32'(i_cmd.table_address);

    grc_ram #(.WIDTH(WORD_W), .DEPTH(INDEX_WORDS)) u_index (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (load_full[IDX_W-1:0]),
        .i_wdata (i_cmd.table_word),
        .i_raddr (addr_full[IDX_W-1:0]),
        .o_rdata (idx_rdata)
    );

    // cache lines: one RAM per way, rows indexed by set
    assign way_waddr = o_clearing ? r_clr : set_idx;
    assign way_wdata = o_clearing ? '0
                     : {1'b1, r_cmd.code_point, i_font_id, r_cmd.glyph_record};

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        grc_ram #(.WIDTH(LINE_W), .DEPTH(SETS)) u_line (
            .i_clk   (i_clk),
            .i_we    (o_clearing || (fill_we && (fill_way == PTR_W'(w)))),
            .i_waddr (way_waddr),
            .i_wdata (way_wdata),
            .i_raddr (set_idx),
            .o_rdata (line[w])
        );
        assign way_hit[w] = line[w][LINE_W-1]
                          && (line[w][LINE_W-2 -: CODE_W] == r_cmd.code_point)
                          && (line[w][REC_W +: FONT_W] == i_font_id);
    end

    grc_ram #(.WIDTH(PTR_W), .DEPTH(SETS)) u_victim (
        .i_clk   (i_clk),
        .i_we    (o_clearing || fill_we),
        .i_waddr (way_waddr),
        .i_wdata (o_clearing ? '0 : fill_next),
        .i_raddr (set_idx),
        .o_rdata (ptr_rdata)
    );

    // lowest matching way wins
    always_comb begin
        hit_any = 1'b0;
        hit_rec = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_hit[w]) begin
                hit_any = 1'b1;
                hit_rec = line[w][REC_W-1:0];
            end
        end
    end

    assign fill_way  = (32'(ptr_rdata) >= WAYS) ? '0 : ptr_rdata;
    assign fill_next = (32'(fill_way) == WAYS - 1) ? '0 : fill_way + PTR_W'(1);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_lvl        = r_lvl;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;
        n_out_num    = r_out_num;
        pop          = 1'b0;
        idx_we       = 1'b0;
        fill_we      = 1'b0;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + SET_W'(1);
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    pop          = 1'b1;
                    n_out_hit    = '0;
                    n_out_num    = '0;
                    n_out_status = ST_DONE;
                    case (i_cmd.op)
                        OP_LOAD: begin
                            idx_we      = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        OP_LOOKUP: n_state = S_TAG;
                        OP_FILL:   n_state = S_FILL;
                        OP_NOFONT: begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NOFONT;
                        end
                        default:   n_out_valid = 1'b1;
                    endcase
                end
            end
            S_TAG: begin
                if (hit_any) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_HIT;
                    n_out_hit    = hit_rec;
                    n_state      = S_IDLE;
                end else begin
                    n_lvl   = walk_lvl;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (idx_rdata == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ABSENT;
                    n_state      = S_IDLE;
                end else if (r_lvl == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_MISS;
                    n_out_num    = idx_rdata - WORD_W'(1);
                    n_state      = S_IDLE;
                end else begin
                    n_lvl = walk_lvl;
                end
            end
            S_FILL: begin
                fill_we     = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_num    <= n_out_num;
    end

    assign o_cmd_pop            = pop;
    assign o_clearing           = (r_state == S_CLEAR);
    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.hit_record   = r_out_hit;
    assign o_result.record_number = r_out_num;
endmodule

FILE: hw/rtl/glyph_radix_index_and_cache_core.sv
// Glyph lookup engine: a round-robin set-associative glyph record cache in front of a
// radix-tree index table. Each item (load, lookup, fill) gives exactly one result. Items
// enter a two-entry queue and are carried out one at a time by the back end; a result sits
// in an output register while the queue keeps taking items. A load or an item with no font
// selected is done in the idle state, a cache hit in the tag state and a fill in the fill
// state; a miss walks the index with one dependent read of the index RAM per level, up to
// RADIX_LEVELS reads, and these reads set the lookup rate. The set is (font_id mod FONT_SETS)
// * CODE_SETS + (code_point mod CODE_SETS); FONT_SETS, CODE_SETS and INDEX_WORDS must be
// powers of two, which the block does not check. After reset a clearing pass over all
// FONT_SETS * CODE_SETS sets (128 by default) invalidates every cache line and victim
// pointer; no item is accepted during it, while configuration writes are taken at any
// time. Write configuration only while the engine is idle.
module glyph_radix_index_and_cache_core #(
    parameter int FONT_SETS    = grc_pkg::FONT_SETS_D,
    parameter int CODE_SETS    = grc_pkg::CODE_SETS_D,
    parameter int WAYS         = grc_pkg::WAYS_D,
    parameter int RADIX_BITS   = grc_pkg::RADIX_BITS_D,
    parameter int RADIX_LEVELS = grc_pkg::RADIX_LEVELS_D,
    parameter int INDEX_WORDS  = grc_pkg::INDEX_WORDS_D
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    grc_in_if.sink                          i_item,
    grc_out_if.source                       o_result
);
    import grc_pkg::*;

    logic [FONT_W-1:0] r_font_id;
    logic              r_font_sel;
    logic [BASE_W-1:0] r_index_base;
    logic              cmd_valid, cmd_pop, clearing;
    t_cmd              cmd;

    // configuration registers; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_id    <= '0;
            r_font_sel   <= 1'b0;
            r_index_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FONT_ID:    r_font_id    <= i_cfg_data[FONT_W-1:0];
                CFG_FONT_SEL:   r_font_sel   <= i_cfg_data[0];
                CFG_INDEX_BASE: r_index_base <= i_cfg_data[BASE_W-1:0];
                default:        ;
            endcase
        end
    end

    // front: accept and classify, queue ahead of the back end
    grc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_font_sel  (r_font_sel),
        .i_clearing  (clearing),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: cache search, index walk, fill, result register
    grc_back #(
        .FONT_SETS    (FONT_SETS),
        .CODE_SETS    (CODE_SETS),
        .WAYS         (WAYS),
        .RADIX_BITS   (RADIX_BITS),
        .RADIX_LEVELS (RADIX_LEVELS),
        .INDEX_WORDS  (INDEX_WORDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_font_id    (r_font_id),
        .i_index_base (r_index_base),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_clearing   (clearing),
        .o_result     (o_result)
    );
endmodule

FILE: hw/rtl/grc_check.sv
// Port-level checks of the glyph lookup engine, bound to its top level.
module grc_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [grc_pkg::STAT_W-1:0]    i_status,
    input logic [grc_pkg::REC_W-1:0]     i_hit_record,
    input logic [grc_pkg::WORD_W-1:0]    i_record_number
);
    import grc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_hit_record)
                                && $stable(i_record_number))
        else $error("stalled result changed");

    a_hit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_HIT) |-> (i_hit_record == '0))
        else $error("record on a non-hit result");

    a_num_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_MISS) |-> (i_record_number == '0))
        else $error("record number on a non-miss result");
endmodule

bind glyph_radix_index_and_cache_core grc_check u_grc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_result.valid),
    .i_ready         (o_result.ready),
    .i_status        (o_result.status),
    .i_hit_record    (o_result.hit_record),
    .i_record_number (o_result.record_number)
);
